// ===== sv/pdrs_pkg.sv =====
// Shared types and constants for the priority memory request scheduler.
// No dependencies; the fifo, the divider and the top level refer to it by scoped names; the bench imports it.
package pdrs_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int QADDR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Field widths
	localparam int TAG_W   = 32;
	localparam int SIZE_W  = 20;
	localparam int OWNER_W = 4;
	localparam int BUSY_W  = 48;

	// Configuration register widths
	localparam int CLAT_W  = 10;
	localparam int DLAT_W  = 12;
	localparam int BPC_W   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Divider: dividend is size + bandwidth - 1
	localparam int NUM_W  = 21;
	localparam int DIV_W  = BPC_W;
	localparam int STEP_W = $clog2(NUM_W);

	// Remaining service cycles
	localparam int CL_W = 21;

	// Command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAM_LAT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BPC       = 2'd2;

	typedef struct packed {
		logic               command;
		logic [TAG_W-1:0]   request_tag;
		logic [SIZE_W-1:0]  size_bytes;
		logic               high_priority;
		logic [OWNER_W-1:0] owner_id;
	} req_t;

	typedef struct packed {
		logic               completed;
		logic [TAG_W-1:0]   done_tag;
		logic [SIZE_W-1:0]  done_size;
		logic               done_priority;
		logic [OWNER_W-1:0] done_owner;
		logic               overflow;
		logic               unit_busy;
		logic [BUSY_W-1:0]  busy_total;
	} rsp_t;

	// One queued memory request
	typedef struct packed {
		logic [TAG_W-1:0]   tag;
		logic [SIZE_W-1:0]  size;
		logic               prio;
		logic [OWNER_W-1:0] owner;
	} entry_t;

	// Queue status seen by the sequencer
	typedef struct packed {
		logic full;
		logic nonempty;
	} fifo_stat_t;

endpackage

// ===== sv/pdrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pdrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/pdrs_fifo.sv =====
// Request queue: head/tail/count pointers around one pdrs_ram instance.
// Depends on pdrs_pkg and pdrs_ram. Head data appears in the cycle after the read.
module pdrs_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  pop,
	input  pdrs_pkg::entry_t      push_data,
	output pdrs_pkg::entry_t      head_data,
	output pdrs_pkg::fifo_stat_t  stat
);

	logic [pdrs_pkg::QADDR_W-1:0] head_q;
	logic [pdrs_pkg::QADDR_W-1:0] tail_q;
	logic [pdrs_pkg::QCNT_W-1:0]  count_q;

	function automatic logic [pdrs_pkg::QADDR_W-1:0] wrap_inc(
		input logic [pdrs_pkg::QADDR_W-1:0] p
	);
		if (p == pdrs_pkg::QADDR_W'(pdrs_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + pdrs_pkg::QADDR_W'(1);
	endfunction

	assign stat.full     = (count_q == pdrs_pkg::QCNT_W'(pdrs_pkg::QUEUE_DEPTH));
	assign stat.nonempty = (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= wrap_inc(tail_q);
			end
			if (pop) begin
				head_q <= wrap_inc(head_q);
			end
			if (push && !pop) begin
				count_q <= count_q + pdrs_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - pdrs_pkg::QCNT_W'(1);
			end
		end
	end

	pdrs_ram #(
		.WIDTH($bits(pdrs_pkg::entry_t)),
		.DEPTH(pdrs_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (push),
		.waddr (tail_q),
		.wdata (push_data),
		.raddr (head_q),
		.rdata (head_data)
	);

endmodule

// ===== sv/pdrs_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on pdrs_pkg. Quotient is valid while done is high.
module pdrs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pdrs_pkg::NUM_W-1:0] dividend,
	input  logic [pdrs_pkg::DIV_W-1:0] divisor,
	output logic                       done,
	output logic [pdrs_pkg::NUM_W-1:0] quotient
);

	logic                        busy_q;
	logic                        done_q;
	logic [pdrs_pkg::STEP_W-1:0] cnt_q;
	logic [pdrs_pkg::DIV_W-1:0]  rem_q;
	logic [pdrs_pkg::NUM_W-1:0]  quot_q;
	logic [pdrs_pkg::DIV_W-1:0]  dvs_q;

	logic [pdrs_pkg::DIV_W:0]    trial;
	logic [pdrs_pkg::DIV_W:0]    diff;
	logic                        ge;

	// Shift the next dividend bit into the partial remainder and try to subtract
	assign trial = {rem_q, quot_q[pdrs_pkg::NUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	assign done     = done_q;
	assign quotient = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + pdrs_pkg::STEP_W'(1);
				if (cnt_q == pdrs_pkg::STEP_W'(pdrs_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[pdrs_pkg::DIV_W-1:0] : trial[pdrs_pkg::DIV_W-1:0];
			quot_q <= {quot_q[pdrs_pkg::NUM_W-2:0], ge};
		end
	end

endmodule

// ===== sv/priority_dram_request_scheduler_unit.sv =====
// Top level of the two-level strict-priority memory request scheduler.
// Depends on pdrs_pkg, pdrs_fifo (two queues) and pdrs_div (transfer time).
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------
//   in      | input     | in_valid / in_stall   | in_req  (pdrs_pkg::req_t)
//   out     | output    | out_valid / out_stall | out_rsp (pdrs_pkg::rsp_t)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A push or a tick that does not start a request is accepted, then loads the
// output register. A tick that starts a request first passes the load and
// divide states, where the serial divider works out ceil(size / bandwidth).
// One request is in flight at a time; in_stall is high until its result is
// loaded into the output register, and a full output register under
// out_stall holds the sequencer in the emit state. Reset clears the queue
// pointers, service state, busy counter and the configuration to its defaults.
module priority_dram_request_scheduler_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  pdrs_pkg::req_t                 in_req,
	output logic                           out_valid,
	input  logic                           out_stall,
	output pdrs_pkg::rsp_t                 out_rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pdrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pdrs_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Configuration
	logic [pdrs_pkg::CLAT_W-1:0] cache_lat_q;
	logic [pdrs_pkg::DLAT_W-1:0] dram_lat_q;
	logic [pdrs_pkg::BPC_W-1:0]  bpc_q;

	// Service state
	logic                        serving_q;
	logic [pdrs_pkg::CL_W-1:0]   cycles_left_q;
	pdrs_pkg::entry_t            active_q;
	logic [pdrs_pkg::BUSY_W-1:0] busy_q;
	logic                        sel_high_q;

	// Per-request result flags
	logic completed_q;
	logic overflow_q;

	// Output register
	logic           out_valid_q;
	pdrs_pkg::rsp_t out_rsp_q;

	// Queues
	pdrs_pkg::entry_t     push_entry;
	pdrs_pkg::entry_t     hi_head;
	pdrs_pkg::entry_t     lo_head;
	pdrs_pkg::entry_t     head_sel;
	pdrs_pkg::fifo_stat_t hi_stat;
	pdrs_pkg::fifo_stat_t lo_stat;
	logic                 hi_push;
	logic                 lo_push;
	logic                 hi_pop;
	logic                 lo_pop;

	// Control decode
	logic acc;
	logic is_push;
	logic is_tick;
	logic emit_load;
	logic [pdrs_pkg::CL_W-1:0] cl_dec;

	// Divider
	logic                       div_start;
	logic                       div_done;
	logic [pdrs_pkg::NUM_W-1:0] div_num;
	logic [pdrs_pkg::DIV_W-1:0] bw_eff;
	logic [pdrs_pkg::NUM_W-1:0] div_quot;
	logic [pdrs_pkg::NUM_W-1:0] xfer;
	logic [pdrs_pkg::CL_W-1:0]  service_cycles;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	assign acc     = in_valid && !in_stall;
	assign is_push = acc && (in_req.command == pdrs_pkg::CMD_PUSH);
	assign is_tick = acc && (in_req.command == pdrs_pkg::CMD_TICK);

	// Route a push to its queue; drop it when that queue is full
	assign push_entry.tag   = in_req.request_tag;
	assign push_entry.size  = in_req.size_bytes;
	assign push_entry.prio  = in_req.high_priority;
	assign push_entry.owner = in_req.owner_id;

	assign hi_push = is_push && in_req.high_priority && !hi_stat.full;
	assign lo_push = is_push && !in_req.high_priority && !lo_stat.full;

	// Idle tick: strict priority, high queue first
	assign hi_pop = is_tick && !serving_q && hi_stat.nonempty;
	assign lo_pop = is_tick && !serving_q && !hi_stat.nonempty && lo_stat.nonempty;

	assign head_sel = sel_high_q ? hi_head : lo_head;

	// Transfer time = ceil(size / bw) as floor((size + bw - 1) / bw)
	assign bw_eff    = (bpc_q == '0) ? pdrs_pkg::DIV_W'(1) : bpc_q;
	assign div_num   = pdrs_pkg::NUM_W'(head_sel.size) + pdrs_pkg::NUM_W'(bw_eff)
		- pdrs_pkg::NUM_W'(1);
	assign div_start = (state_q == ST_LOAD);

	assign xfer = (div_quot == '0) ? pdrs_pkg::NUM_W'(1) : div_quot;
	assign service_cycles = pdrs_pkg::CL_W'(cache_lat_q) + pdrs_pkg::CL_W'(dram_lat_q)
		+ pdrs_pkg::CL_W'(xfer);

	assign cl_dec = (cycles_left_q != '0) ? (cycles_left_q - pdrs_pkg::CL_W'(1))
		: cycles_left_q;

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	pdrs_fifo u_hi_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (hi_push),
		.pop       (hi_pop),
		.push_data (push_entry),
		.head_data (hi_head),
		.stat      (hi_stat)
	);

	pdrs_fifo u_lo_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (lo_push),
		.pop       (lo_pop),
		.push_data (push_entry),
		.head_data (lo_head),
		.stat      (lo_stat)
	);

	pdrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (bw_eff),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cache_lat_q   <= pdrs_pkg::CLAT_W'(10);
			dram_lat_q    <= pdrs_pkg::DLAT_W'(100);
			bpc_q         <= pdrs_pkg::BPC_W'(64);
			serving_q     <= 1'b0;
			cycles_left_q <= '0;
			active_q      <= '0;
			busy_q        <= '0;
			sel_high_q    <= 1'b0;
			completed_q   <= 1'b0;
			overflow_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			out_rsp_q     <= '0;
		end else begin
			// The user writes configuration only while idle; the block does not enforce it
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pdrs_pkg::CFG_CACHE_LAT: cache_lat_q <= cfg_data[pdrs_pkg::CLAT_W-1:0];
					pdrs_pkg::CFG_DRAM_LAT:  dram_lat_q  <= cfg_data[pdrs_pkg::DLAT_W-1:0];
					pdrs_pkg::CFG_BPC:       bpc_q       <= cfg_data[pdrs_pkg::BPC_W-1:0];
					default: ;
				endcase
			end

			// Drop the output once taken, unless a new result loads this cycle
			if (!out_stall && !emit_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (is_push) begin
							completed_q <= 1'b0;
							overflow_q  <= in_req.high_priority ? hi_stat.full : lo_stat.full;
							state_q     <= ST_EMIT;
						end else if (serving_q) begin
							// Count the busy tick and advance the service countdown
							if (busy_q != '1) begin
								busy_q <= busy_q + pdrs_pkg::BUSY_W'(1);
							end
							cycles_left_q <= cl_dec;
							serving_q     <= (cl_dec != '0);
							completed_q   <= (cl_dec == '0);
							overflow_q    <= 1'b0;
							state_q       <= ST_EMIT;
						end else begin
							// Head read is in flight; pick it up next cycle
							completed_q <= 1'b0;
							overflow_q  <= 1'b0;
							sel_high_q  <= hi_stat.nonempty;
							state_q     <= (hi_stat.nonempty || lo_stat.nonempty) ? ST_LOAD
								: ST_EMIT;
						end
					end
				end
				ST_LOAD: begin
					active_q <= head_sel;
					state_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						cycles_left_q <= service_cycles;
						serving_q     <= 1'b1;
						state_q       <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						out_valid_q             <= 1'b1;
						out_rsp_q.completed     <= completed_q;
						out_rsp_q.done_tag      <= completed_q ? active_q.tag : '0;
						out_rsp_q.done_size     <= completed_q ? active_q.size : '0;
						out_rsp_q.done_priority <= completed_q ? active_q.prio : 1'b0;
						out_rsp_q.done_owner    <= completed_q ? active_q.owner : '0;
						out_rsp_q.overflow      <= overflow_q;
						out_rsp_q.unit_busy     <= serving_q || hi_stat.nonempty
							|| lo_stat.nonempty;
						out_rsp_q.busy_total    <= busy_q;
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The divider only finishes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// A request in service always has a nonzero remaining-cycle count
	a_serving_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		serving_q |-> (cycles_left_q != '0))
		else $error("serving with no cycles left");

	// An idle tick with a queued request starts the head read
	a_idle_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(is_tick && !serving_q && (hi_stat.nonempty || lo_stat.nonempty))
		|=> (state_q == ST_LOAD))
		else $error("idle tick with queued request did not start service");

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for priority_dram_request_scheduler_unit: push/tick requests
// against an in-bench queue and service-time predictor, with random idling.
// Depends on pdrs_pkg and the scheduler RTL; needs no files or arguments.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pdrs_pkg::*;

	// Track the scheduler state and hold one expected result per accepted request.
	class request_schedule_checker;
		int unsigned       cache_lat;
		int unsigned       dram_lat;
		int unsigned       bytes_cyc;
		entry_t            high_fifo[$];
		entry_t            low_fifo[$];
		bit                serving;
		int unsigned       cycles_left;
		entry_t            active;
		logic [BUSY_W-1:0] busy_tally;
		rsp_t              pending_results[$];
		int                accepted;
		int                checked;
		int                errors;

		function new();
			cache_lat   = 10;
			dram_lat    = 100;
			bytes_cyc   = 64;
			serving     = 1'b0;
			cycles_left = 0;
			active      = '0;
			busy_tally  = '0;
			accepted    = 0;
			checked     = 0;
			errors      = 0;
		endfunction

		function bit unit_active();
			return serving || (high_fifo.size() != 0) || (low_fifo.size() != 0);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_CACHE_LAT: cache_lat = data[CLAT_W-1:0];
				CFG_DRAM_LAT:  dram_lat  = data[DLAT_W-1:0];
				CFG_BPC:       bytes_cyc = data[BPC_W-1:0];
				default: ;
			endcase
		endfunction

		// Load a request into service; zero bandwidth counts as one byte per cycle.
		function void begin_service(entry_t ent);
			int unsigned bw;
			int unsigned xfer;
			bw = (bytes_cyc == 0) ? 1 : bytes_cyc;
			xfer = (int'(ent.size) + bw - 1) / bw;
			if (xfer == 0)
				xfer = 1;
			active      = ent;
			serving     = 1'b1;
			cycles_left = cache_lat + dram_lat + xfer;
		endfunction

		function void note_request(req_t r);
			rsp_t   exp;
			entry_t ent;
			exp = '0;
			accepted++;
			if (r.command == CMD_PUSH) begin
				ent.tag   = r.request_tag;
				ent.size  = r.size_bytes;
				ent.prio  = r.high_priority;
				ent.owner = r.owner_id;
				if (r.high_priority) begin
					if (high_fifo.size() >= QUEUE_DEPTH)
						exp.overflow = 1'b1;
					else
						high_fifo.push_back(ent);
				end else begin
					if (low_fifo.size() >= QUEUE_DEPTH)
						exp.overflow = 1'b1;
					else
						low_fifo.push_back(ent);
				end
			end else if (serving) begin
				if (busy_tally != '1)
					busy_tally++;
				if (cycles_left > 0)
					cycles_left--;
				if (cycles_left == 0) begin
					serving           = 1'b0;
					exp.completed     = 1'b1;
					exp.done_tag      = active.tag;
					exp.done_size     = active.size;
					exp.done_priority = active.prio;
					exp.done_owner    = active.owner;
				end
			end else if (high_fifo.size() != 0) begin
				begin_service(high_fifo.pop_front());
			end else if (low_fifo.size() != 0) begin
				begin_service(low_fifo.pop_front());
			end
			exp.unit_busy  = unit_active();
			exp.busy_total = busy_tally;
			pending_results.push_back(exp);
		endfunction

		function void flag(string field, logic [63:0] want, logic [63:0] seen);
			if (want !== seen) begin
				errors++;
				if (errors <= 10)
					$display("result %0d: %s expected %0h, got %0h", checked, field, want, seen);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t exp;
			checked++;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %0d: nothing expected, got %h", checked, got);
				return;
			end
			exp = pending_results.pop_front();
			flag("completed", exp.completed, got.completed);
			flag("done_tag", exp.done_tag, got.done_tag);
			flag("done_size", exp.done_size, got.done_size);
			flag("done_priority", exp.done_priority, got.done_priority);
			flag("done_owner", exp.done_owner, got.done_owner);
			flag("overflow", exp.overflow, got.overflow);
			flag("unit_busy", exp.unit_busy, got.unit_busy);
			flag("busy_total", exp.busy_total, got.busy_total);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	req_t                  in_req;
	logic                  out_valid;
	logic                  out_stall;
	rsp_t                  out_rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	request_schedule_checker sb = new();

	priority_dram_request_scheduler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// A stretch of requests during which neither side idles.
	function automatic bit steady_span(int n);
		return (n >= 250) && (n < 330);
	endfunction

	function automatic req_t push_item(logic [TAG_W-1:0] tag, logic [SIZE_W-1:0] sz,
	                                   logic prio, logic [OWNER_W-1:0] owner);
		req_t r;
		r.command       = CMD_PUSH;
		r.request_tag   = tag;
		r.size_bytes    = sz;
		r.high_priority = prio;
		r.owner_id      = owner;
		return r;
	endfunction

	// A tick carries random payload bits, which the block must ignore.
	function automatic req_t tick_item();
		req_t r;
		r.command       = CMD_TICK;
		r.request_tag   = $urandom;
		r.size_bytes    = SIZE_W'($urandom);
		r.high_priority = 1'($urandom);
		r.owner_id      = OWNER_W'($urandom);
		return r;
	endfunction

	// Offer one request, starting at a falling edge; hold it until accepted.
	task automatic issue(input req_t r);
		while (!steady_span(sb.accepted) && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_req   <= r;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
		@(negedge clk);
	endtask

	// Tick until the predicted unit is idle: every queued request completes.
	task automatic drain_service();
		while (sb.unit_active())
			issue(tick_item());
	endtask

	// Write a register once all results are back, so the block is idle.
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
	                           input logic [CFG_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Program a setting, optionally overrun both queues, then run a random mix of
	// pushes and ticks in bursts of push-heavy, balanced and tick-heavy traffic, and drain at the end.
	task automatic run_phase(input logic [CFG_DATA_W-1:0] clat, input logic [CFG_DATA_W-1:0] dlat,
	                         input logic [CFG_DATA_W-1:0] bpc, input int cap,
	                         input int count, input bit fill);
		int                push_pct;
		logic [SIZE_W-1:0] sz;
		program_reg(CFG_CACHE_LAT, clat);
		program_reg(CFG_DRAM_LAT, dlat);
		program_reg(CFG_BPC, bpc);
		// Overrun both queues so each one reports a dropped request.
		if (fill) begin
			for (int i = 0; i < 2 * QUEUE_DEPTH + 4; i++)
				issue(push_item($urandom, SIZE_W'($urandom_range(0, cap)), i[0],
				                OWNER_W'($urandom)));
		end
		push_pct = 50;
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				case ($urandom_range(0, 2))
					0:       push_pct = 15;
					1:       push_pct = 50;
					default: push_pct = 90;
				endcase
			end
			if ($urandom_range(0, 99) < push_pct) begin
				sz = SIZE_W'($urandom_range(0, cap));
				issue(push_item($urandom, sz, 1'($urandom), OWNER_W'($urandom)));
			end else begin
				issue(tick_item());
			end
		end
		drain_service();
	endtask

	// Check every result taken by the receiver at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_rsp);
	end

	// Receiver: random stalls, one long hold-off so the block backs up, and a
	// stretch with no stalls at all.
	initial begin : receiver
		int hold_left;
		bit held;
		hold_left = 0;
		held      = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sb.checked >= 120) begin
				held      = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (steady_span(sb.checked)) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 7);
			end
		end
	end

	initial begin : stimulus
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_req    = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, under the reset configuration: idle tick on empty queues,
		// field extremes, low request queued behind a high one, push while serving.
		issue(tick_item());
		issue(push_item('0, '0, 1'b0, '0));
		issue(push_item('1, SIZE_W'(100), 1'b1, '1));
		issue(push_item(32'hA5A5_5A5A, SIZE_W'(64), 1'b0, OWNER_W'(5)));
		issue(tick_item());
		issue(push_item(32'h0000_1234, SIZE_W'(1), 1'b1, OWNER_W'(9)));
		issue(tick_item());
		// Finish the request in service on its reset-time count; queued ones
		// start with zero cache and DRAM latency.
		program_reg(CFG_CACHE_LAT, 12'd0);
		program_reg(CFG_DRAM_LAT, 12'd0);
		drain_service();

		// Random phases: zero bandwidth with queue overrun, bandwidth above
		// range (data masked to 11 bits), and a bandwidth of 1024.
		run_phase(12'd0, 12'd0, 12'd0, 1, 24, 1'b1);
		run_phase(12'd2, 12'd1, 12'hFFF, 5000, 24, 1'b0);
		run_phase(12'd1, 12'd2, 12'd1024, 3000, 24, 1'b0);

		// Largest latencies: cache data masked to 10 bits; start one full-size
		// request and count a few busy ticks.
		program_reg(CFG_CACHE_LAT, 12'hFFF);
		program_reg(CFG_DRAM_LAT, 12'd4095);
		program_reg(CFG_BPC, 12'd1024);
		issue(push_item($urandom, '1, 1'b1, OWNER_W'($urandom)));
		issue(tick_item());
		issue(tick_item());
		issue(tick_item());

		// Let the last results arrive, then watch for strays.
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("[priority_dram_request_scheduler_unit] OK");
		else
			$display("[priority_dram_request_scheduler_unit] ERROR");
		$finish;
	end

	// Bound the run well beyond the slowest correct completion.
	initial begin : watchdog
		#20ms;
		$display("[priority_dram_request_scheduler_unit] ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/pdrs_pkg.sv
sv/pdrs_ram.sv
sv/pdrs_fifo.sv
sv/pdrs_div.sv
sv/priority_dram_request_scheduler_unit.sv
sim/tb.sv
